### sv/burh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burh_pkg: shared types for the bounded undo/redo history
// Command codes and the status bundle passed from the control unit to the
// result pipeline.
// ----------------------------------------------------------------------------
package burh_pkg;

  // Command codes carried in the input tuser field.
  // Codes above CMD_QUERY behave as a query.
  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_PUSH  = 3'd1,
    CMD_BACK  = 3'd2,
    CMD_FWD   = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_t;

  // Per-command status, computed from the state after the command.
  typedef struct packed {
    logic ok;
    logic show_entry;
    logic back_available;
    logic forward_available;
  } status_t;

  localparam int unsigned CMD_BITS  = 3;
  localparam int unsigned WORD_BITS = 64;

endpackage

### sv/bounded_undo_redo_history_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_undo_redo_history_top: bounded undo/redo history of snapshot words
// Stream-in commands, stream-out one result word per command.
// ----------------------------------------------------------------------------
// The block takes one command word per clock cycle while in_tready is high
// and returns exactly one result word for each, in order. A result passes
// through the history store, a RAM with a registered read port, and then
// the output register: the command updates the cursor, count and oldest
// slot in its accept cycle and issues the store access, and the read data
// joins the result, held in stage one while the output side stalls, before
// it is loaded into the output register. Commands: clear, push, step back,
// step forward and query; unused codes act as a query. A successful step
// returns the snapshot at the new cursor; every other result carries zero
// data. The store itself has no reset: reads only ever reach entries that a
// push has written, so no clearing pass is needed after reset.
module bounded_undo_redo_history_top #(
  parameter int unsigned HISTORY_DEPTH = 64,
  parameter int unsigned ENTRY_BITS    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] entry_in
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] entry_out
  output logic [2:0]  out_tuser   // [0] ok, [1] back_available, [2] forward_available
);

  logic                       in_accept;
  logic                       advance;
  burh_pkg::status_t          status;
  logic [ENTRY_BITS-1:0]      rd_data;

  // Stage one holds the status of a command whose store read is in flight.
  logic                       p1_valid_r;
  burh_pkg::status_t          p1_status_r;

  // Output register.
  logic                       out_valid_r;
  logic [2:0]                 out_user_r;
  logic [burh_pkg::WORD_BITS-1:0] out_data_r;

  // Stage one moves on whenever the output register is free or being taken.
  // A new command may enter as stage one moves on, so the store read data
  // stays put while stage one is stalled.
  assign advance   = p1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  burh_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .ENTRY_BITS    (ENTRY_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_accept (in_accept),
    .cmd        (in_tuser),
    .entry_in   (in_tdata[ENTRY_BITS-1:0]),
    .status     (status),
    .rd_data    (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (in_accept) begin
      p1_valid_r <= 1'b1;
    end else if (advance) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p1_status_r <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Only a successful step shows the store word; everything else reads zero.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_user_r <= {p1_status_r.forward_available, p1_status_r.back_available,
                     p1_status_r.ok};
      out_data_r <= p1_status_r.show_entry ? burh_pkg::WORD_BITS'(rd_data) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

### sv/burh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burh_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module burh_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### sv/burh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burh_ctrl: history state and store addressing
// Holds the oldest slot, entry count and cursor, decodes one command per
// cycle, applies it when cmd_accept is high, and drives the history store.
// ----------------------------------------------------------------------------
module burh_ctrl #(
  parameter int unsigned HISTORY_DEPTH = 64,
  parameter int unsigned ENTRY_BITS    = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_accept,
  input  logic [burh_pkg::CMD_BITS-1:0] cmd,
  input  logic [ENTRY_BITS-1:0]         entry_in,
  output burh_pkg::status_t             status,
  output logic [ENTRY_BITS-1:0]         rd_data
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(HISTORY_DEPTH);

  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] clamped;
  logic [CW-1:0] push_base;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          ok, show_entry;

  // Physical slot of a position counted from the oldest entry. The sum stays
  // below twice the depth, so one conditional subtract wraps it.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(pos);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    if (cursor_r == '0) begin
      clamped = CW'(1);
    end else if (cursor_r > count_r) begin
      clamped = count_r;
    end else begin
      clamped = cursor_r;
    end
    push_base = (count_r > cursor_r) ? cursor_r : count_r;
  end

  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = slot_of(oldest_r, push_base);
    rd_addr    = '0;
    ok         = 1'b0;
    show_entry = 1'b0;
    case (burh_pkg::cmd_t'(cmd))
      burh_pkg::CMD_CLEAR: begin
        oldest_nxt = '0;
        count_nxt  = '0;
        cursor_nxt = '0;
      end
      burh_pkg::CMD_PUSH: begin
        wr_en = 1'b1;
        ok    = 1'b1;
        if (push_base == DEPTH_C) begin
          // Store full: the new word overwrites the oldest slot.
          oldest_nxt = slot_of(oldest_r, CW'(1));
          count_nxt  = DEPTH_C;
        end else begin
          count_nxt = push_base + CW'(1);
        end
        cursor_nxt = count_nxt;
      end
      burh_pkg::CMD_BACK: begin
        if (count_r != '0) begin
          cursor_nxt = clamped;
          if (clamped > CW'(1)) begin
            cursor_nxt = clamped - CW'(1);
            rd_en      = 1'b1;
            rd_addr    = slot_of(oldest_r, clamped - CW'(2));
            ok         = 1'b1;
            show_entry = 1'b1;
          end
        end
      end
      burh_pkg::CMD_FWD: begin
        if (count_r != '0) begin
          cursor_nxt = clamped;
          if (clamped < count_r) begin
            cursor_nxt = clamped + CW'(1);
            rd_en      = 1'b1;
            rd_addr    = slot_of(oldest_r, clamped);
            ok         = 1'b1;
            show_entry = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.ok                = ok;
    status.show_entry        = show_entry;
    status.back_available    = (cursor_nxt > CW'(1));
    status.forward_available = (cursor_nxt < count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
      cursor_r <= '0;
    end else if (cmd_accept) begin
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  burh_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en && cmd_accept),
    .wr_addr   (wr_addr),
    .wr_data   (entry_in),
    .rd_en     (rd_en && cmd_accept),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

endmodule

### sv/burh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burh_checker: port-level checks for the undo/redo history
// Watches the stream ports of the top level and is bound to it.
// ----------------------------------------------------------------------------
module burh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [2:0]  out_tuser
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] pending_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Commands accepted whose result word has not been taken yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  // At most two commands are in flight: one awaiting its read, one in output.
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd2)
    else $error("more than two commands in flight");

  // A result never appears without an outstanding command.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != 3'd0)
    else $error("result word without a pending command");

  // A result without ok set carries zero data.
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tdata == 64'd0)
    else $error("nonzero data on a result that did not succeed");

  // With the output side empty and no command pending, the block always takes a command.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid && pending_r == 3'd0) |-> in_tready)
    else $error("command refused while the block is empty");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

endmodule

bind bounded_undo_redo_history_top burh_checker u_burh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### dv/bounded_undo_redo_history_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_undo_redo_history_top_tb: self-checking bench for the undo/redo history
// Drives clear, push, step and query commands over the input stream and checks
// every result word against a cycle-free model of the cursor, the entry count
// and the circular snapshot store, under random idling on both sides.
// ----------------------------------------------------------------------------

// Tracks the history state as the block should see it and queues one expected
// result word per accepted command.
class history_scoreboard;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned SNAP_BITS  = 64;
  localparam logic [63:0] SNAP_MASK  = {64{1'b1}} >> (64 - SNAP_BITS);
  localparam int unsigned OK_BIT     = 0;
  localparam int unsigned BACK_BIT   = 1;
  localparam int unsigned FWD_BIT    = 2;

  typedef struct {
    logic        ok;
    logic [63:0] snap;
    logic        can_back;
    logic        can_fwd;
  } history_result_t;

  logic [63:0]     snap_mem [DEPTH];
  int unsigned     base_slot;
  int unsigned     depth_used;
  int unsigned     pos;
  history_result_t pending_results [$];

  int unsigned errors;
  int unsigned n_cmds;
  int unsigned n_pushes;
  int unsigned n_moves;
  int unsigned n_wraps;
  int unsigned n_checked;

  function new();
    base_slot  = 0;
    depth_used = 0;
    pos        = 0;
    errors     = 0;
    n_cmds     = 0;
    n_pushes   = 0;
    n_moves    = 0;
    n_wraps    = 0;
    n_checked  = 0;
  endfunction

  function int unsigned slot_at(int unsigned idx);
    return (base_slot + idx) % DEPTH;
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction

  // Applies one accepted command word and records the result it must produce.
  function void note_command(logic [2:0] cmd, logic [63:0] snap_in);
    history_result_t r;
    r.ok   = 1'b0;
    r.snap = '0;
    n_cmds++;
    case (cmd)
      burh_pkg::CMD_CLEAR: begin
        depth_used = 0;
        pos        = 0;
        base_slot  = 0;
      end
      burh_pkg::CMD_PUSH: begin
        if (depth_used > pos) depth_used = pos;
        snap_mem[slot_at(depth_used)] = snap_in & SNAP_MASK;
        depth_used++;
        if (depth_used > DEPTH) begin
          base_slot  = slot_at(1);
          depth_used = DEPTH;
          n_wraps++;
        end
        pos = depth_used;
        r.ok = 1'b1;
        n_pushes++;
      end
      burh_pkg::CMD_BACK, burh_pkg::CMD_FWD: begin
        if (depth_used >= 1) begin
          if (pos < 1) pos = 1;
          if (pos > depth_used) pos = depth_used;
          if (cmd == burh_pkg::CMD_BACK && pos > 1) begin
            pos--;
            r.ok = 1'b1;
          end else if (cmd == burh_pkg::CMD_FWD && pos < depth_used) begin
            pos++;
            r.ok = 1'b1;
          end
          if (r.ok) begin
            r.snap = snap_mem[slot_at(pos - 1)] & SNAP_MASK;
            n_moves++;
          end
        end
      end
      default: ;
    endcase
    r.can_back = (pos > 1);
    r.can_fwd  = (pos < depth_used);
    pending_results.push_back(r);
  endfunction

  // Compares one accepted result word with the oldest expectation.
  function void check_result(logic [63:0] data, logic [2:0] flags);
    history_result_t r;
    if (pending_results.size() == 0) begin
      $error("result word arrived with no pending expectation");
      errors++;
      return;
    end
    r = pending_results.pop_front();
    n_checked++;
    if (flags[OK_BIT] !== r.ok) begin
      $error("ok mismatch: expected %0d, actual %0d", r.ok, flags[OK_BIT]);
      errors++;
    end
    if (data !== r.snap) begin
      $error("entry_out mismatch: expected %h, actual %h", r.snap, data);
      errors++;
    end
    if (flags[BACK_BIT] !== r.can_back) begin
      $error("back_available mismatch: expected %0d, actual %0d",
             r.can_back, flags[BACK_BIT]);
      errors++;
    end
    if (flags[FWD_BIT] !== r.can_fwd) begin
      $error("forward_available mismatch: expected %0d, actual %0d",
             r.can_fwd, flags[FWD_BIT]);
      errors++;
    end
  endfunction

endclass

module bounded_undo_redo_history_top_tb;

  // Command codes the package leaves unnamed; the block treats them as a query.
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  // Words per random phase, and the number of pushes that open each phase so
  // the store wraps at least once per phase.
  localparam int unsigned PHASE_WORDS = 445;
  localparam int unsigned FILL_BURST  = 72;

  // Long receiver hold-off used to back the block up into its input.
  localparam int unsigned HOLD_CYCLES = 300;

  // Watchdog limit, far above the length of a correct run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [63:0] entry_in
  logic [2:0]  in_tuser;   // [2:0] cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [63:0] entry_out
  logic [2:0]  out_tuser;  // [0] ok, [1] back_available, [2] forward_available

  history_scoreboard sb = new();

  // Idle percentages for the sender and the receiver, changed per phase.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  // Set by the stimulus to ask the receiver process for one long hold-off.
  bit          hold_req;
  int unsigned cycle_count;

  bounded_undo_redo_history_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offers one command word and returns once the block has taken it. The valid
  // line is only lowered when an idle cycle is actually inserted, so a valid
  // that stays high from one word to the next is never toggled within a step.
  task automatic send_word(input logic [2:0] cmd, input logic [63:0] snap);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= snap;
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, snap);
  endtask

  // Random snapshot word, with the all-zero and all-one patterns mixed in.
  function automatic logic [63:0] rand_snap();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // A short run of hand-picked commands covering the boundary behavior.
  task automatic run_directed();
    // Steps and queries on an empty history must all fail without changes.
    send_word(burh_pkg::CMD_BACK, '1);
    send_word(burh_pkg::CMD_FWD, '1);
    send_word(burh_pkg::CMD_QUERY, '0);
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
      send_word(c[2:0], {$urandom(), $urandom()});
    // Three entries with the data extremes.
    send_word(burh_pkg::CMD_PUSH, '0);
    send_word(burh_pkg::CMD_PUSH, '1);
    send_word(burh_pkg::CMD_PUSH, 64'hA5A5_5A5A_0F0F_F0F0);
    // Walk back past the oldest entry, then forward past the newest.
    send_word(burh_pkg::CMD_BACK, '0);
    send_word(burh_pkg::CMD_BACK, '0);
    send_word(burh_pkg::CMD_BACK, '0);
    send_word(burh_pkg::CMD_FWD, '0);
    send_word(burh_pkg::CMD_FWD, '0);
    send_word(burh_pkg::CMD_FWD, '0);
    // A push from the middle of the history drops the newer entries.
    send_word(burh_pkg::CMD_BACK, '0);
    send_word(burh_pkg::CMD_PUSH, 64'h8000_0000_0000_0001);
    send_word(burh_pkg::CMD_QUERY, '1);
    send_word(burh_pkg::CMD_FWD, '0);
    // Clear, then check that the history really is empty.
    send_word(burh_pkg::CMD_CLEAR, '1);
    send_word(burh_pkg::CMD_BACK, '0);
    send_word(burh_pkg::CMD_PUSH, 64'h0123_4567_89AB_CDEF);
    send_word(burh_pkg::CMD_QUERY, '0);
  endtask

  // One random phase: a push burst that overfills the store, then a mix that
  // drifts upward in depth so the wraparound stays in play between clears.
  task automatic run_random(input int unsigned n_words);
    int unsigned sel;
    logic [2:0]  cmd;
    for (int unsigned k = 0; k < n_words; k++) begin
      sel = $urandom_range(99);
      if (k < FILL_BURST) cmd = burh_pkg::CMD_PUSH;
      else if (sel < 2)   cmd = burh_pkg::CMD_CLEAR;
      else if (sel < 45)  cmd = burh_pkg::CMD_PUSH;
      else if (sel < 72)  cmd = burh_pkg::CMD_BACK;
      else if (sel < 93)  cmd = burh_pkg::CMD_FWD;
      else if (sel < 96)  cmd = burh_pkg::CMD_QUERY;
      else                cmd = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
      send_word(cmd, rand_snap());
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request. Each
  // cycle gets at most one assignment to out_tready.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result monitor: every accepted result word goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Watchdog: a run that does not drain within the limit is a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bounded_undo_redo_history_top verification failed");
    $finish;
  end

  // Main sequence: reset, directed part, three random phases with different
  // idling, then drain and report.
  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= burh_pkg::CMD_QUERY;
    hold_req    = 1'b0;
    tx_idle_pct = 28;
    rx_idle_pct = 82;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender mostly busy, receiver mostly stalled.
    run_directed();
    run_random(PHASE_WORDS);

    // Phase two: the roles swap.
    tx_idle_pct = 82;
    rx_idle_pct = 28;
    run_random(PHASE_WORDS);

    // Phase three: no idling, opened by a long receiver hold-off so the
    // block fills up and has to stall its input while the sender keeps going.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    run_random(PHASE_WORDS);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words for %0d commands under three idling mixes.",
             sb.n_checked, sb.n_cmds);
    $display("Saw %0d pushes (%0d into a full store) and %0d steps that moved the cursor.",
             sb.n_pushes, sb.n_wraps, sb.n_moves);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("bounded_undo_redo_history_top verification clean");
    end else begin
      $display("bounded_undo_redo_history_top verification failed");
    end
    $finish;
  end

endmodule
